// File: rtl/core/rlp_pkg.sv
// Shared constants, codes and payload types for the RGB LED pulse pipeline.
// Used by rlp_ramp, rlp_dim, rgb_led_pulse_from_knobs_top and the testbench; depends on nothing.
package rlp_pkg;

    localparam int ADC_W          = 12;
    localparam int PWM_W          = 16;
    localparam int ADC_FULL_SCALE = 4096;
    localparam int NUM_SEGS       = 6;
    localparam int SEG_LEN        = ADC_FULL_SCALE / NUM_SEGS;
    localparam int POS_W          = $clog2(SEG_LEN);
    localparam int SEG_W          = 3;
    localparam int RAW_W          = PWM_W + POS_W;
    localparam int RECIP_SHIFT    = 36;
    localparam int RECIP_W        = 27;
    localparam int PROD_W         = RAW_W + RECIP_W;
    localparam int SCALE_W        = PWM_W + ADC_W;
    localparam longint unsigned RECIP = (64'd1 << RECIP_SHIFT) / SEG_LEN;
    localparam logic [PWM_W-1:0] PERIOD_RESET = 16'd4095;

    typedef enum logic [1:0] {
        ACT_STANDBY  = 2'd0,
        ACT_HUE      = 2'd1,
        ACT_KNOB_CAL = 2'd2,
        ACT_LED_CAL  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        TGT_KNOB1 = 2'd0,
        TGT_KNOB2 = 2'd1,
        TGT_KNOB3 = 2'd2,
        TGT_NONE  = 2'd3
    } t_target;

    typedef enum logic [SEG_W-1:0] {
        SEG_RED_YELLOW    = 3'd0,
        SEG_YELLOW_GREEN  = 3'd1,
        SEG_GREEN_CYAN    = 3'd2,
        SEG_CYAN_BLUE     = 3'd3,
        SEG_BLUE_MAGENTA  = 3'd4,
        SEG_MAGENTA_RED   = 3'd5,
        SEG_TAIL_RED      = 3'd6
    } t_seg;

    typedef struct packed {
        t_action            action;
        t_target            target;
        logic [ADC_W-1:0]   knob_one;
        logic [ADC_W-1:0]   knob_two;
        logic [ADC_W-1:0]   knob_three;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_req;

    typedef struct packed {
        logic               valid;
        t_item              item;
        t_seg               seg;
        logic [PWM_W-1:0]   ramp;
    } t_ramp_res;

    typedef struct packed {
        logic               dim_en;
        logic [PWM_W-1:0]   level;
        logic [ADC_W-1:0]   knob;
    } t_dim_in;

    function automatic logic [ADC_W-1:0] seg_base(input t_seg s);
        return ADC_W'(int'(s) * SEG_LEN);
    endfunction

endpackage

// File: rtl/core/rlp_ramp.sv
// Four-stage hue front end: segment split of the reversed color knob and
// ramp = period * pos / SEG_LEN by reciprocal multiply. Depends on rlp_pkg.
module rlp_ramp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rlp_pkg::PWM_W-1:0]      i_pwm_period,
    input  rlp_pkg::t_req                  i_req,
    output rlp_pkg::t_ramp_res             o_res
);

    logic [rlp_pkg::ADC_W-1:0]   colour;
    rlp_pkg::t_seg               n_seg;
    logic [rlp_pkg::PROD_W-1:0]  recip_prod;
    logic [rlp_pkg::RAW_W-1:0]   rem;

    logic                        r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld;
    rlp_pkg::t_item              r_s1_item, r_s2_item, r_s3_item, r_s4_item;
    rlp_pkg::t_seg               r_s1_seg, r_s2_seg, r_s3_seg, r_s4_seg;
    logic [rlp_pkg::POS_W-1:0]   r_s1_pos;
    logic [rlp_pkg::RAW_W-1:0]   r_s2_raw, r_s3_raw;
    logic [rlp_pkg::PWM_W-1:0]   r_s3_quot, r_s4_ramp;

    assign colour = rlp_pkg::ADC_W'(rlp_pkg::ADC_FULL_SCALE - 1) - i_req.item.knob_two;

    always_comb begin
        n_seg = rlp_pkg::SEG_RED_YELLOW;
        for (int i = 1; i <= rlp_pkg::NUM_SEGS; i++) begin
            if (colour >= rlp_pkg::ADC_W'(i * rlp_pkg::SEG_LEN)) begin
                n_seg = rlp_pkg::t_seg'(rlp_pkg::SEG_W'(i));
            end
        end
    end

    assign recip_prod = rlp_pkg::PROD_W'(r_s2_raw) * rlp_pkg::PROD_W'(rlp_pkg::RECIP);
    assign rem = r_s3_raw - rlp_pkg::RAW_W'(r_s3_quot) * rlp_pkg::RAW_W'(rlp_pkg::SEG_LEN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_req.valid;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_item <= i_req.item;
        r_s1_seg  <= n_seg;
        r_s1_pos  <= rlp_pkg::POS_W'(colour - rlp_pkg::seg_base(n_seg));

        r_s2_item <= r_s1_item;
        r_s2_seg  <= r_s1_seg;
        r_s2_raw  <= rlp_pkg::RAW_W'(i_pwm_period) * rlp_pkg::RAW_W'(r_s1_pos);

        r_s3_item <= r_s2_item;
        r_s3_seg  <= r_s2_seg;
        r_s3_raw  <= r_s2_raw;
        r_s3_quot <= recip_prod[rlp_pkg::RECIP_SHIFT +: rlp_pkg::PWM_W];

        r_s4_item <= r_s3_item;
        r_s4_seg  <= r_s3_seg;
        r_s4_ramp <= r_s3_quot + rlp_pkg::PWM_W'(rem >= rlp_pkg::RAW_W'(rlp_pkg::SEG_LEN));
    end

    assign o_res.valid = r_s4_vld;
    assign o_res.item  = r_s4_item;
    assign o_res.seg   = r_s4_seg;
    assign o_res.ramp  = r_s4_ramp;

    a_ramp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s4_vld |-> (r_s4_ramp <= i_pwm_period))
        else $error("ramp exceeds period");

    a_ramp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |-> ##4 o_res.valid)
        else $error("ramp result lost");

endmodule

// File: rtl/core/rlp_dim.sv
// Two-stage brightness lane: level + knob * (period - level) / full scale,
// or the level unchanged when dimming is off. Depends on rlp_pkg.
module rlp_dim (
    input  logic                           i_clk,
    input  logic [rlp_pkg::PWM_W-1:0]      i_pwm_period,
    input  rlp_pkg::t_dim_in               i_dim,
    output logic [rlp_pkg::PWM_W-1:0]      o_pulse
);

    logic                          r_dim_en;
    logic [rlp_pkg::PWM_W-1:0]     r_level;
    logic [rlp_pkg::SCALE_W-1:0]   r_prod;
    logic [rlp_pkg::PWM_W-1:0]     r_pulse;
    logic [rlp_pkg::PWM_W-1:0]     n_pulse;

    always_comb begin
        if (r_dim_en) begin
            n_pulse = r_level + r_prod[rlp_pkg::SCALE_W-1 -: rlp_pkg::PWM_W];
        end else begin
            n_pulse = r_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dim_en <= i_dim.dim_en;
        r_level  <= i_dim.level;
        r_prod   <= rlp_pkg::SCALE_W'(i_dim.knob)
                    * rlp_pkg::SCALE_W'(i_pwm_period - i_dim.level);
        r_pulse  <= n_pulse;
    end

    assign o_pulse = r_pulse;

endmodule

// File: rtl/core/rgb_led_pulse_from_knobs_top.sv
// An accepted request gives its strobe after passing rlp_ramp, the stage-5 register and the rlp_dim lane.
// Throughput: one request per cycle; busy is always low, and the receiver cannot stall.
// Standby requests are dropped at entry and give no strobe.
// Synchronous active-low reset clears the valid pipeline and sets the period to 4095.
// Holds the period register, color selection and scaling stage, and the three dim lanes.
// Depends on rlp_pkg, rlp_ramp and rlp_dim.
module rgb_led_pulse_from_knobs_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlp_pkg::PWM_W-1:0]      i_cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     i_action,
    input  logic [1:0]                     i_cal_target,
    input  logic [rlp_pkg::ADC_W-1:0]      i_knob_one,
    input  logic [rlp_pkg::ADC_W-1:0]      i_knob_two,
    input  logic [rlp_pkg::ADC_W-1:0]      i_knob_three,
    output logic                           o_strobe,
    output logic [rlp_pkg::PWM_W-1:0]      o_red_pulse,
    output logic [rlp_pkg::PWM_W-1:0]      o_green_pulse,
    output logic [rlp_pkg::PWM_W-1:0]      o_blue_pulse
);

    logic [rlp_pkg::PWM_W-1:0]     r_pwm_period;
    rlp_pkg::t_req                 req;
    rlp_pkg::t_ramp_res            ramp_res;

    logic [rlp_pkg::PWM_W-1:0]     p, ramp;
    logic [rlp_pkg::PWM_W-1:0]     sel_r, sel_g, sel_b;
    logic [rlp_pkg::ADC_W-1:0]     knob_g, knob_b;
    logic [rlp_pkg::SCALE_W-1:0]   prod_r, prod_g, prod_b;
    logic [rlp_pkg::PWM_W-1:0]     cal_r, cal_g, cal_b;
    logic                          is_hue, knob_cal, one_target;
    rlp_pkg::t_dim_in              n_dim_r, n_dim_g, n_dim_b;

    logic                          r_s5_vld, r_s6_vld, r_s7_vld;
    rlp_pkg::t_dim_in              r_s5_dim_r, r_s5_dim_g, r_s5_dim_b;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= rlp_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_pwm_period <= i_cfg_wdata;
        end
    end

    assign req.valid = start && !busy
                       && (rlp_pkg::t_action'(i_action) != rlp_pkg::ACT_STANDBY);
    assign req.item.action     = rlp_pkg::t_action'(i_action);
    assign req.item.target     = rlp_pkg::t_target'(i_cal_target);
    assign req.item.knob_one   = i_knob_one;
    assign req.item.knob_two   = i_knob_two;
    assign req.item.knob_three = i_knob_three;

    rlp_ramp u_ramp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pwm_period (r_pwm_period),
        .i_req        (req),
        .o_res        (ramp_res)
    );

    assign p    = r_pwm_period;
    assign ramp = ramp_res.ramp;

    always_comb begin
        unique case (ramp_res.seg)
            rlp_pkg::SEG_RED_YELLOW: begin
                sel_r = p;        sel_g = ramp;     sel_b = '0;
            end
            rlp_pkg::SEG_YELLOW_GREEN: begin
                sel_r = p - ramp; sel_g = p;        sel_b = '0;
            end
            rlp_pkg::SEG_GREEN_CYAN: begin
                sel_r = '0;       sel_g = p;        sel_b = ramp;
            end
            rlp_pkg::SEG_CYAN_BLUE: begin
                sel_r = '0;       sel_g = p - ramp; sel_b = p;
            end
            rlp_pkg::SEG_BLUE_MAGENTA: begin
                sel_r = ramp;     sel_g = '0;       sel_b = p;
            end
            rlp_pkg::SEG_MAGENTA_RED: begin
                sel_r = p;        sel_g = '0;       sel_b = p - ramp;
            end
            default: begin
                sel_r = p;        sel_g = '0;       sel_b = '0;
            end
        endcase
    end

    assign is_hue     = (ramp_res.item.action == rlp_pkg::ACT_HUE);
    assign knob_cal   = (ramp_res.item.action == rlp_pkg::ACT_KNOB_CAL);
    assign one_target = knob_cal && (ramp_res.item.target != rlp_pkg::TGT_NONE);

    assign knob_g = (knob_cal && !one_target) ? ramp_res.item.knob_one
                                              : ramp_res.item.knob_two;
    assign knob_b = (knob_cal && !one_target) ? ramp_res.item.knob_one
                                              : ramp_res.item.knob_three;

    assign prod_r = rlp_pkg::SCALE_W'(ramp_res.item.knob_one) * rlp_pkg::SCALE_W'(p);
    assign prod_g = rlp_pkg::SCALE_W'(knob_g) * rlp_pkg::SCALE_W'(p);
    assign prod_b = rlp_pkg::SCALE_W'(knob_b) * rlp_pkg::SCALE_W'(p);

    assign cal_r = (one_target && ramp_res.item.target != rlp_pkg::TGT_KNOB1) ? p
                   : prod_r[rlp_pkg::SCALE_W-1 -: rlp_pkg::PWM_W];
    assign cal_g = (one_target && ramp_res.item.target != rlp_pkg::TGT_KNOB2) ? p
                   : prod_g[rlp_pkg::SCALE_W-1 -: rlp_pkg::PWM_W];
    assign cal_b = (one_target && ramp_res.item.target != rlp_pkg::TGT_KNOB3) ? p
                   : prod_b[rlp_pkg::SCALE_W-1 -: rlp_pkg::PWM_W];

    always_comb begin
        n_dim_r.dim_en = is_hue;
        n_dim_g.dim_en = is_hue;
        n_dim_b.dim_en = is_hue;
        n_dim_r.knob   = ramp_res.item.knob_one;
        n_dim_g.knob   = ramp_res.item.knob_one;
        n_dim_b.knob   = ramp_res.item.knob_one;
        n_dim_r.level  = is_hue ? (p - sel_r) : cal_r;
        n_dim_g.level  = is_hue ? (p - sel_g) : cal_g;
        n_dim_b.level  = is_hue ? (p - sel_b) : cal_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
        end else begin
            r_s5_vld <= ramp_res.valid;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_dim_r <= n_dim_r;
        r_s5_dim_g <= n_dim_g;
        r_s5_dim_b <= n_dim_b;
    end

    rlp_dim u_dim_red (
        .i_clk        (i_clk),
        .i_pwm_period (r_pwm_period),
        .i_dim        (r_s5_dim_r),
        .o_pulse      (o_red_pulse)
    );

    rlp_dim u_dim_green (
        .i_clk        (i_clk),
        .i_pwm_period (r_pwm_period),
        .i_dim        (r_s5_dim_g),
        .o_pulse      (o_green_pulse)
    );

    rlp_dim u_dim_blue (
        .i_clk        (i_clk),
        .i_pwm_period (r_pwm_period),
        .i_dim        (r_s5_dim_b),
        .o_pulse      (o_blue_pulse)
    );

    assign o_strobe = r_s7_vld;

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid |-> ##7 o_strobe)
        else $error("accepted request produced no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(req.valid, 7))
        else $error("result without a matching request");

    a_pulse_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_red_pulse <= r_pwm_period) && (o_green_pulse <= r_pwm_period)
                     && (o_blue_pulse <= r_pwm_period))
        else $error("pulse value above period");

endmodule

// File: tb/rgb_led_pulse_from_knobs_top_test.sv
// Self-checking testbench for rgb_led_pulse_from_knobs_top: drives knob requests and period writes,
// predicts the three PWM compare values per request and checks every strobed result.
// Depends on rlp_pkg and the rgb_led_pulse_from_knobs_top RTL.
module rgb_led_pulse_from_knobs_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rlp_pkg::*;

    typedef struct packed {
        logic [PWM_W-1:0] red;
        logic [PWM_W-1:0] green;
        logic [PWM_W-1:0] blue;
    } t_pulses;

    class led_pulse_scoreboard;
        logic [PWM_W-1:0] period;
        t_pulses          expected_pulses[$];
        int               failures;
        int               requests;
        int               results;

        function new();
            period   = PERIOD_RESET;
            failures = 0;
            requests = 0;
            results  = 0;
        endfunction

        function logic [PWM_W-1:0] scale_knob(logic [ADC_W-1:0] knob);
            longint unsigned full;
            longint unsigned v;
            full = ADC_FULL_SCALE;
            v = (64'(knob) * 64'(period)) / full;
            return (v > 64'(period)) ? period : v[PWM_W-1:0];
        endfunction

        function logic [PWM_W-1:0] dim_level(logic [PWM_W-1:0] level, logic [ADC_W-1:0] k1);
            longint unsigned full;
            longint unsigned v;
            full = ADC_FULL_SCALE;
            v = 64'(level) + (64'(k1) * 64'(period - level)) / full;
            return (v > 64'(period)) ? period : v[PWM_W-1:0];
        endfunction

        function void note_request(t_action act, t_target tgt, logic [ADC_W-1:0] k1,
                                   logic [ADC_W-1:0] k2, logic [ADC_W-1:0] k3);
            longint unsigned seg_len;
            longint unsigned colour;
            longint unsigned pos;
            logic [PWM_W-1:0] ramp;
            t_seg    seg;
            t_pulses p;
            if (act == ACT_STANDBY) begin
                return;
            end
            requests++;
            case (act)
                ACT_HUE: begin
                    seg_len = ADC_FULL_SCALE / NUM_SEGS;
                    colour  = ADC_FULL_SCALE - 1 - k2;
                    seg     = t_seg'(colour / seg_len);
                    pos     = colour % seg_len;
                    ramp    = PWM_W'((64'(period) * pos) / seg_len);
                    case (seg)
                        SEG_RED_YELLOW:   p = '{period, ramp, '0};
                        SEG_YELLOW_GREEN: p = '{period - ramp, period, '0};
                        SEG_GREEN_CYAN:   p = '{'0, period, ramp};
                        SEG_CYAN_BLUE:    p = '{'0, period - ramp, period};
                        SEG_BLUE_MAGENTA: p = '{ramp, '0, period};
                        SEG_MAGENTA_RED:  p = '{period, '0, period - ramp};
                        default:          p = '{period, '0, '0};
                    endcase
                    p.red   = dim_level(period - p.red, k1);
                    p.green = dim_level(period - p.green, k1);
                    p.blue  = dim_level(period - p.blue, k1);
                end
                ACT_KNOB_CAL: begin
                    case (tgt)
                        TGT_KNOB1: p = '{scale_knob(k1), period, period};
                        TGT_KNOB2: p = '{period, scale_knob(k2), period};
                        TGT_KNOB3: p = '{period, period, scale_knob(k3)};
                        default:   p = '{scale_knob(k1), scale_knob(k1), scale_knob(k1)};
                    endcase
                end
                default: begin
                    p = '{scale_knob(k1), scale_knob(k2), scale_knob(k3)};
                end
            endcase
            expected_pulses.push_back(p);
        endfunction

        function void check_pulses(logic [PWM_W-1:0] red, logic [PWM_W-1:0] green,
                                   logic [PWM_W-1:0] blue);
            t_pulses e;
            results++;
            if (expected_pulses.size() == 0) begin
                $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
                failures++;
                return;
            end
            e = expected_pulses.pop_front();
            if (red !== e.red) begin
                $error("red_pulse: expected %0d, actual %0d", e.red, red);
                failures++;
            end
            if (green !== e.green) begin
                $error("green_pulse: expected %0d, actual %0d", e.green, green);
                failures++;
            end
            if (blue !== e.blue) begin
                $error("blue_pulse: expected %0d, actual %0d", e.blue, blue);
                failures++;
            end
        endfunction

        function int pending();
            return expected_pulses.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [PWM_W-1:0] i_cfg_wdata;
    logic             start;
    logic             busy;
    logic [1:0]       i_action;
    logic [1:0]       i_cal_target;
    logic [ADC_W-1:0] i_knob_one;
    logic [ADC_W-1:0] i_knob_two;
    logic [ADC_W-1:0] i_knob_three;
    logic             o_strobe;
    logic [PWM_W-1:0] o_red_pulse;
    logic [PWM_W-1:0] o_green_pulse;
    logic [PWM_W-1:0] o_blue_pulse;

    led_pulse_scoreboard sb;
    int                  period_settings;

    rgb_led_pulse_from_knobs_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_cal_target  (i_cal_target),
        .i_knob_one    (i_knob_one),
        .i_knob_two    (i_knob_two),
        .i_knob_three  (i_knob_three),
        .o_strobe      (o_strobe),
        .o_red_pulse   (o_red_pulse),
        .o_green_pulse (o_green_pulse),
        .o_blue_pulse  (o_blue_pulse)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            sb.check_pulses(o_red_pulse, o_green_pulse, o_blue_pulse);
        end
    end

    task automatic drive_request(t_action act, t_target tgt, logic [ADC_W-1:0] k1,
                                 logic [ADC_W-1:0] k2, logic [ADC_W-1:0] k3);
        start        = 1'b1;
        i_action     = act;
        i_cal_target = tgt;
        i_knob_one   = k1;
        i_knob_two   = k2;
        i_knob_three = k3;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        sb.note_request(act, tgt, k1, k2, k3);
        @(negedge i_clk);
    endtask

    task automatic drain_pipeline();
        start = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
    endtask

    task automatic write_period(logic [PWM_W-1:0] value);
        drain_pipeline();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we  = 1'b0;
        sb.period = value;
        period_settings++;
    endtask

    function automatic logic [ADC_W-1:0] pick_knob();
        int s;
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: begin
                s = $urandom_range(1, NUM_SEGS);
                return ADC_W'(ADC_FULL_SCALE - 1 - s * (ADC_FULL_SCALE / NUM_SEGS)
                              + $urandom_range(2) - 1);
            end
            default: return ADC_W'($urandom_range(ADC_FULL_SCALE - 1));
        endcase
    endfunction

    task automatic run_random(int count, int idle_pct, bit pause_midway);
        int     sent;
        int     pick;
        t_action act;
        sent = 0;
        while (sent < count) begin
            while ($urandom_range(99) < idle_pct) begin
                start = 1'b0;
                @(negedge i_clk);
            end
            if (pause_midway && sent == count / 2) begin
                drain_pipeline();
                pause_midway = 1'b0;
            end
            pick = $urandom_range(99);
            if (pick < 8) begin
                act = ACT_STANDBY;
            end else if (pick < 58) begin
                act = ACT_HUE;
            end else if (pick < 79) begin
                act = ACT_KNOB_CAL;
            end else begin
                act = ACT_LED_CAL;
            end
            drive_request(act, t_target'($urandom_range(3)), pick_knob(), pick_knob(),
                          pick_knob());
            sent++;
        end
        start = 1'b0;
    endtask

    initial begin
        sb              = new();
        period_settings = 1;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        start           = 1'b0;
        i_action        = ACT_STANDBY;
        i_cal_target    = TGT_KNOB1;
        i_knob_one      = '0;
        i_knob_two      = '0;
        i_knob_three    = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd0, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd4095, 12'd3, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd4, 12'd4095);
        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd4095, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd4095, 12'd4095, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd2048, 12'd3413, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd3414, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd2731, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd1, 12'd2049, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd1000, 12'd1367, 12'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd0, 12'd685, 12'd0);
        drive_request(ACT_STANDBY, TGT_KNOB1, 12'd4095, 12'd4095, 12'd4095);
        drive_request(ACT_KNOB_CAL, TGT_KNOB1, 12'd4095, 12'd0, 12'd0);
        drive_request(ACT_KNOB_CAL, TGT_KNOB2, 12'd0, 12'd4095, 12'd0);
        drive_request(ACT_KNOB_CAL, TGT_KNOB3, 12'd4095, 12'd4095, 12'd4095);
        drive_request(ACT_KNOB_CAL, TGT_NONE, 12'd4095, 12'd7, 12'd9);
        drive_request(ACT_KNOB_CAL, TGT_NONE, 12'd0, 12'd4095, 12'd4095);
        drive_request(ACT_LED_CAL, TGT_KNOB1, 12'd0, 12'd0, 12'd0);
        drive_request(ACT_LED_CAL, TGT_NONE, 12'd4095, 12'd4095, 12'd4095);
        drive_request(ACT_LED_CAL, TGT_KNOB2, 12'd1, 12'd2048, 12'd4094);
        write_period(16'd0);
        drive_request(ACT_HUE, TGT_NONE, 12'd2048, 12'd1500, 12'd0);
        drive_request(ACT_LED_CAL, TGT_NONE, 12'd4095, 12'd4095, 12'd4095);
        write_period(16'd65535);
        drive_request(ACT_HUE, TGT_NONE, 12'd2047, 12'd3000, 12'd0);
        drive_request(ACT_KNOB_CAL, TGT_NONE, 12'd4095, 12'd0, 12'd0);

        write_period(PERIOD_RESET);
        run_random(140, 14, 1'b0);
        write_period(16'd65535);
        run_random(140, 14, 1'b0);
        write_period(16'd1);
        run_random(140, 74, 1'b0);
        write_period(16'($urandom_range(2, 65534)));
        run_random(140, 74, 1'b1);
        write_period(16'd4096);
        run_random(145, 0, 1'b0);
        write_period(16'($urandom_range(1, 65535)));
        run_random(145, 0, 1'b0);

        drain_pipeline();
        $display("Checked %0d results from %0d requests across %0d period settings,",
                 sb.results, sb.requests, period_settings);
        $display("covering hue segments, both calibration modes and periods 0, 1 and 65535.");
        if (sb.failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #100000;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rlp_pkg.sv
rtl/core/rlp_ramp.sv
rtl/core/rlp_dim.sv
rtl/core/rgb_led_pulse_from_knobs_top.sv
tb/rgb_led_pulse_from_knobs_top_test.sv
